// ===== src/frefl_pkg.sv =====
package frefl_pkg;

   localparam int REFL_W   = 16;
   localparam int COS_W    = 16;
   localparam int ETA_W    = 16;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 48;

   localparam logic [REFL_W-1:0] ONE_Q15 = 16'h8000;
   localparam logic [30:0]       ONE_Q30 = 31'h4000_0000;

   // Cycles from the registered cosine to each unit's registered result
   localparam int DIE_LAT  = 70;
   localparam int COND_LAT = 78;

   typedef enum logic [1:0] {
      MODE_DIELECTRIC = 2'd0,
      MODE_CONDUCTOR  = 2'd1,
      MODE_PASS       = 2'd2
   } mode_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_MODE       = 3'd0,
      CSR_DIE_ETA_I  = 3'd1,
      CSR_DIE_ETA_T  = 3'd2,
      CSR_COND_ETA_I = 3'd3,
      CSR_COND_ETA_T = 3'd4,
      CSR_COND_ABS   = 3'd5
   } csr_index_type;

endpackage

// ===== src/frefl_delay.sv =====
module frefl_delay import frefl_pkg::*; #(
   parameter int W = 1,
   parameter int N = 1
) (
   input  logic         clock,
   input  logic [W-1:0] d_in,
   output logic [W-1:0] d_out
);

   logic [W-1:0] tap_ff [N];

   always_ff @(posedge clock) begin
      tap_ff[0] <= d_in;
      for (int i = 1; i < N; i++) begin
         tap_ff[i] <= tap_ff[i-1];
      end
   end

   assign d_out = tap_ff[N-1];

endmodule

// ===== src/frefl_isqrt.sv =====
// Floor square root, one result bit per stage.
module frefl_isqrt import frefl_pkg::*; #(
   parameter int IN_W = 32,
   localparam int OUT_W = IN_W / 2
) (
   input  logic             clock,
   input  logic [IN_W-1:0]  rad,
   output logic [OUT_W-1:0] root
);

   logic [IN_W-1:0] x_ff [OUT_W];
   logic [IN_W-1:0] r_ff [OUT_W];

   for (genvar i = 0; i < OUT_W; i++) begin : g_stage
      localparam logic [IN_W:0] BIT = (IN_W+1)'(1) << (2 * (OUT_W - 1 - i));
      logic [IN_W-1:0] x_prev, r_prev, x_in, r_in;
      logic [IN_W:0]   trial;

      always_comb begin
         if (i == 0) begin
            x_prev = rad;
            r_prev = '0;
         end else begin
            x_prev = x_ff[(i == 0) ? 0 : i-1];
            r_prev = r_ff[(i == 0) ? 0 : i-1];
         end
         trial = {1'b0, r_prev} + BIT;
         if ({1'b0, x_prev} >= trial) begin
            x_in = IN_W'({1'b0, x_prev} - trial);
            r_in = (r_prev >> 1) + IN_W'(BIT);
         end else begin
            x_in = x_prev;
            r_in = r_prev >> 1;
         end
      end

      always_ff @(posedge clock) begin
         x_ff[i] <= x_in;
         r_ff[i] <= r_in;
      end
   end

   assign root = r_ff[OUT_W-1][OUT_W-1:0];

endmodule

// ===== src/frefl_div.sv =====
// Restoring divider: quotient of {hi, lo} / den, hi taken once against den
// and then one bit of lo per stage.
module frefl_div import frefl_pkg::*; #(
   parameter int DW = 32,
   parameter int QW = 16
) (
   input  logic          clock,
   input  logic [DW-1:0] hi,
   input  logic [QW-1:0] lo,
   input  logic [DW-1:0] den,
   output logic [QW:0]   quo
);

   logic [DW-1:0] rem_ff [QW+1];
   logic [QW-1:0] lo_ff  [QW+1];
   logic [DW-1:0] den_ff [QW+1];
   logic [QW:0]   q_ff   [QW+1];

   always_ff @(posedge clock) begin
      if (hi >= den) begin
         rem_ff[0] <= hi - den;
         q_ff[0]   <= (QW+1)'(1) << QW;
      end else begin
         rem_ff[0] <= hi;
         q_ff[0]   <= '0;
      end
      lo_ff[0]  <= lo;
      den_ff[0] <= den;
   end

   for (genvar k = 1; k <= QW; k++) begin : g_step
      logic [DW:0]   shifted;
      logic [DW-1:0] rem_in;
      logic [QW:0]   q_in;

      always_comb begin
         shifted = {rem_ff[k-1], lo_ff[k-1][QW-k]};
         q_in    = q_ff[k-1];
         if (shifted >= {1'b0, den_ff[k-1]}) begin
            rem_in      = DW'(shifted - {1'b0, den_ff[k-1]});
            q_in[QW-k]  = 1'b1;
         end else begin
            rem_in = DW'(shifted);
         end
      end

      always_ff @(posedge clock) begin
         rem_ff[k] <= rem_in;
         lo_ff[k]  <= lo_ff[k-1];
         den_ff[k] <= den_ff[k-1];
         q_ff[k]   <= q_in;
      end
   end

   assign quo = q_ff[QW];

endmodule

// ===== src/frefl_dielectric.sv =====
module frefl_dielectric import frefl_pkg::*; (
   input  logic                     clock,
   input  logic signed [COS_W-1:0]  cos_theta,
   input  logic [ETA_W-1:0]         eta_i,
   input  logic [ETA_W-1:0]         eta_t,
   output logic [REFL_W-1:0]        refl,
   output logic                     tir
);

   // stage 1: magnitude and index swap on exit
   logic        neg;
   logic [15:0] c1_ff, ei1_ff, et1_ff;

   assign neg = cos_theta[COS_W-1] || (cos_theta == '0);

   always_ff @(posedge clock) begin
      c1_ff  <= neg ? unsigned'(-cos_theta) : unsigned'(cos_theta);
      ei1_ff <= neg ? eta_t : eta_i;
      et1_ff <= neg ? eta_i : eta_t;
   end

   // stage 2: squares
   logic [30:0] c2_ff;
   logic [31:0] ei2_ff, et2_ff;
   logic [15:0] c2p_ff, ei2p_ff, et2p_ff;

   always_ff @(posedge clock) begin
      c2_ff   <= 31'(32'(c1_ff) * 32'(c1_ff));
      ei2_ff  <= 32'(ei1_ff) * 32'(ei1_ff);
      et2_ff  <= 32'(et1_ff) * 32'(et1_ff);
      c2p_ff  <= c1_ff;
      ei2p_ff <= ei1_ff;
      et2p_ff <= et1_ff;
   end

   // stage 3: etaI^2 * sin^2
   logic [61:0] lhs_ff;
   logic [31:0] et2b_ff;
   logic [15:0] c3_ff, ei3_ff, et3_ff;

   always_ff @(posedge clock) begin
      lhs_ff  <= 62'(ei2_ff) * 62'(ONE_Q30 - c2_ff);
      et2b_ff <= et2_ff;
      c3_ff   <= c2p_ff;
      ei3_ff  <= ei2p_ff;
      et3_ff  <= et2p_ff;
   end

   logic etz3, tir3;
   assign etz3 = (et3_ff == '0);
   assign tir3 = (lhs_ff >= {et2b_ff, 30'd0});

   logic [30:0] quo;
   frefl_div #(.DW(32), .QW(30)) u_div_sin (
      .clock (clock),
      .hi    (lhs_ff[61:30]),
      .lo    (lhs_ff[29:0]),
      .den   (et2b_ff),
      .quo   (quo)
   );

   logic [15:0] ct;
   frefl_isqrt #(.IN_W(32)) u_sqrt_cos (
      .clock (clock),
      .rad   (32'(ONE_Q30) - {2'b00, quo[29:0]}),
      .root  (ct)
   );

   logic [49:0] side_a;
   frefl_delay #(.W(50), .N(47)) u_side_a (
      .clock (clock),
      .d_in  ({c3_ff, ei3_ff, et3_ff, etz3, tir3}),
      .d_out (side_a)
   );

   // stage 4: cross products
   logic [31:0] a1_ff, b1_ff, a2_ff, b2_ff;
   logic        force4_ff, tir4_ff;

   always_ff @(posedge clock) begin
      a1_ff     <= 32'(side_a[17:2]) * 32'(side_a[49:34]);
      b1_ff     <= 32'(side_a[33:18]) * 32'(ct);
      a2_ff     <= 32'(side_a[33:18]) * 32'(side_a[49:34]);
      b2_ff     <= 32'(side_a[17:2]) * 32'(ct);
      force4_ff <= side_a[1] | side_a[0];
      tir4_ff   <= side_a[0] & ~side_a[1];
   end

   logic [32:0] num1, den1, num2, den2;
   assign den1 = 33'(a1_ff) + 33'(b1_ff);
   assign num1 = (a1_ff >= b1_ff) ? 33'(a1_ff - b1_ff) : 33'(b1_ff - a1_ff);
   assign den2 = 33'(a2_ff) + 33'(b2_ff);
   assign num2 = (a2_ff >= b2_ff) ? 33'(a2_ff - b2_ff) : 33'(b2_ff - a2_ff);

   logic [16:0] q1, q2;
   frefl_div #(.DW(33), .QW(16)) u_div_rs (
      .clock (clock), .hi (num1), .lo ('0), .den (den1), .quo (q1)
   );
   frefl_div #(.DW(33), .QW(16)) u_div_rp (
      .clock (clock), .hi (num2), .lo ('0), .den (den2), .quo (q2)
   );

   logic [1:0] side_b;
   frefl_delay #(.W(2), .N(17)) u_side_b (
      .clock (clock),
      .d_in  ({force4_ff | (den1 == '0) | (den2 == '0), tir4_ff}),
      .d_out (side_b)
   );

   // stage 5: squares of the two ratios
   logic [33:0] sq1_ff, sq2_ff;
   logic        force5_ff, tir5_ff;

   always_ff @(posedge clock) begin
      sq1_ff    <= 34'(q1) * 34'(q1);
      sq2_ff    <= 34'(q2) * 34'(q2);
      force5_ff <= side_b[1];
      tir5_ff   <= side_b[0];
   end

   // stage 6: average, round, saturate
   logic [34:0] sum;
   logic [16:0] rnd;
   logic [REFL_W-1:0] refl_ff;
   logic              tir_ff;

   assign sum = 35'(sq1_ff) + 35'(sq2_ff) + 35'(1 << 17);
   assign rnd = sum[34:18];

   always_ff @(posedge clock) begin
      if (force5_ff || rnd > 17'(ONE_Q15)) refl_ff <= ONE_Q15;
      else                                  refl_ff <= rnd[15:0];
      tir_ff <= tir5_ff;
   end

   assign refl = refl_ff;
   assign tir  = tir_ff;

endmodule

// ===== src/frefl_conductor.sv =====
module frefl_conductor import frefl_pkg::*; (
   input  logic                     clock,
   input  logic signed [COS_W-1:0]  cos_theta,
   input  logic [ETA_W-1:0]         eta_i,
   input  logic [ETA_W-1:0]         eta_t,
   input  logic [ETA_W-1:0]         kappa,
   output logic [REFL_W-1:0]        refl
);

   logic [15:0] c;
   assign c = cos_theta[COS_W-1] ? unsigned'(-cos_theta) : unsigned'(cos_theta);

   // C1: squares and plain products
   logic [30:0] c2_1_ff, ci_1_ff;
   logic [31:0] i2_1_ff, e2_1_ff, k2_1_ff, ek_1_ff;

   always_ff @(posedge clock) begin
      c2_1_ff <= 31'(32'(c) * 32'(c));
      ci_1_ff <= 31'(32'(c) * 32'(eta_i));
      i2_1_ff <= 32'(eta_i) * 32'(eta_i);
      e2_1_ff <= 32'(eta_t) * 32'(eta_t);
      k2_1_ff <= 32'(kappa) * 32'(kappa);
      ek_1_ff <= 32'(eta_t) * 32'(kappa);
   end

   // C2: Q30 products with sin^2
   logic [30:0] s2_1;
   logic [62:0] m_full, mc_full;
   logic [61:0] ss_full;
   assign s2_1    = ONE_Q30 - c2_1_ff;
   assign m_full  = 63'(s2_1) * 63'(i2_1_ff);
   assign mc_full = 63'(c2_1_ff) * 63'(i2_1_ff);
   assign ss_full = 62'(s2_1) * 62'(s2_1);

   logic [31:0]        m_2_ff, mc_2_ff, i2_2_ff;
   logic [30:0]        ss_2_ff, c2_2_ff, s2_2_ff, ci_2_ff;
   logic signed [33:0] d_2_ff;
   logic [32:0]        v_2_ff;

   always_ff @(posedge clock) begin
      m_2_ff  <= m_full[61:30];
      mc_2_ff <= mc_full[61:30];
      ss_2_ff <= ss_full[60:30];
      d_2_ff  <= {2'b00, e2_1_ff} - {2'b00, k2_1_ff};
      v_2_ff  <= {ek_1_ff, 1'b0};
      i2_2_ff <= i2_1_ff;
      c2_2_ff <= c2_1_ff;
      s2_2_ff <= s2_1;
      ci_2_ff <= ci_1_ff;
   end

   // C3: t0 and its magnitude
   logic signed [34:0] t0_in;
   logic [62:0]        mss_full;
   assign t0_in    = {d_2_ff[33], d_2_ff} - {3'b000, m_2_ff};
   assign mss_full = 63'(ss_2_ff) * 63'(i2_2_ff);

   logic signed [34:0] t0_3_ff;
   logic [32:0]        ut0_3_ff, v_3_ff;
   logic [31:0]        mss_3_ff, mc_3_ff;
   logic [30:0]        c2_3_ff, s2_3_ff, ci_3_ff;

   always_ff @(posedge clock) begin
      t0_3_ff  <= t0_in;
      ut0_3_ff <= t0_in[34] ? 33'(-t0_in) : 33'(t0_in);
      v_3_ff   <= v_2_ff;
      mss_3_ff <= mss_full[61:30];
      mc_3_ff  <= mc_2_ff;
      c2_3_ff  <= c2_2_ff;
      s2_3_ff  <= s2_2_ff;
      ci_3_ff  <= ci_2_ff;
   end

   // C4: common shift so both terms fit 31 bits
   logic [32:0] both;
   logic [1:0]  sh;
   assign both = ut0_3_ff | v_3_ff;
   always_comb begin
      priority if (both[32]) sh = 2'd2;
      else if (both[31])     sh = 2'd1;
      else                   sh = 2'd0;
   end

   logic [30:0]        us_4_ff, vs_4_ff;
   logic [1:0]         sh_4_ff;
   logic [191:0]       pass_4_ff;

   always_ff @(posedge clock) begin
      us_4_ff   <= 31'(ut0_3_ff >> sh);
      vs_4_ff   <= 31'(v_3_ff >> sh);
      sh_4_ff   <= sh;
      pass_4_ff <= {t0_3_ff, c2_3_ff, s2_3_ff, mc_3_ff, mss_3_ff, ci_3_ff};
   end

   // C5: squares for the hypotenuse
   logic [61:0]  usq_5_ff, vsq_5_ff;
   logic [193:0] pass_5_ff;

   always_ff @(posedge clock) begin
      usq_5_ff  <= 62'(us_4_ff) * 62'(us_4_ff);
      vsq_5_ff  <= 62'(vs_4_ff) * 62'(vs_4_ff);
      pass_5_ff <= {sh_4_ff, pass_4_ff};
   end

   logic [31:0] hyp_root;
   frefl_isqrt #(.IN_W(64)) u_sqrt_hyp (
      .clock (clock),
      .rad   (64'(usq_5_ff) + 64'(vsq_5_ff)),
      .root  (hyp_root)
   );

   logic [193:0] side_a;
   frefl_delay #(.W(194), .N(32)) u_side_a (
      .clock (clock), .d_in (pass_5_ff), .d_out (side_a)
   );

   // C7: scale the root back
   logic [33:0]  a_7_ff;
   logic [191:0] pass_7_ff;

   always_ff @(posedge clock) begin
      a_7_ff    <= 34'(hyp_root) << side_a[193:192];
      pass_7_ff <= side_a[191:0];
   end

   // C8: (A + t0) / 2, clamped at zero
   logic signed [34:0] t0_7;
   logic [35:0]        hs;
   assign t0_7 = pass_7_ff[191:157];
   assign hs   = {2'b00, a_7_ff} + {t0_7[34], t0_7};

   logic [33:0]  hh_8_ff, a_8_ff;
   logic [156:0] pass_8_ff;

   always_ff @(posedge clock) begin
      hh_8_ff   <= hs[35] ? '0 : hs[34:1];
      a_8_ff    <= a_7_ff;
      pass_8_ff <= pass_7_ff[156:0];
   end

   logic [16:0] ah;
   frefl_isqrt #(.IN_W(34)) u_sqrt_h (
      .clock (clock), .rad (hh_8_ff), .root (ah)
   );

   logic [190:0] side_b;
   frefl_delay #(.W(191), .N(17)) u_side_b (
      .clock (clock), .d_in ({a_8_ff, pass_8_ff}), .d_out (side_b)
   );

   // side_b: A, c2, s2, mc, mss, ci
   logic [33:0] a_b;
   logic [30:0] c2_b, s2_b, ci_b;
   logic [31:0] mc_b, mss_b;
   assign {a_b, c2_b, s2_b, mc_b, mss_b, ci_b} = side_b;

   // C9: y1 and x1
   logic [47:0] y1_full;
   assign y1_full = 48'(ci_b) * 48'(ah);

   logic [33:0] y1_9_ff, a_9_ff;
   logic [34:0] x1_9_ff;
   logic [30:0] c2_9_ff, s2_9_ff;
   logic [31:0] mss_9_ff;

   always_ff @(posedge clock) begin
      y1_9_ff  <= y1_full[47:14];
      x1_9_ff  <= 35'(a_b) + 35'(mc_b);
      a_9_ff   <= a_b;
      c2_9_ff  <= c2_b;
      s2_9_ff  <= s2_b;
      mss_9_ff <= mss_b;
   end

   // C10: first ratio terms, second ratio products
   logic [64:0] x2a_full, y2_full;
   assign x2a_full = 65'(c2_9_ff) * 65'(a_9_ff);
   assign y2_full  = 65'(s2_9_ff) * 65'(y1_9_ff);

   logic [35:0] num1_10_ff, den1_10_ff;
   logic [34:0] x2a_10_ff, y2_10_ff;
   logic [31:0] mss_10_ff;

   always_ff @(posedge clock) begin
      num1_10_ff <= (x1_9_ff > 35'(y1_9_ff)) ? 36'(x1_9_ff - 35'(y1_9_ff)) : '0;
      den1_10_ff <= 36'(x1_9_ff) + 36'(y1_9_ff);
      x2a_10_ff  <= x2a_full[64:30];
      y2_10_ff   <= y2_full[64:30];
      mss_10_ff  <= mss_9_ff;
   end

   // C11: second ratio terms
   logic [35:0] x2;
   assign x2 = 36'(x2a_10_ff) + 36'(mss_10_ff);

   logic [35:0] num1_11_ff, den1_11_ff, num2_11_ff, den2_11_ff;

   always_ff @(posedge clock) begin
      num1_11_ff <= num1_10_ff;
      den1_11_ff <= den1_10_ff;
      num2_11_ff <= (x2 > 36'(y2_10_ff)) ? x2 - 36'(y2_10_ff) : '0;
      den2_11_ff <= x2 + 36'(y2_10_ff);
   end

   logic [16:0] rs, f;
   frefl_div #(.DW(36), .QW(16)) u_div_rs (
      .clock (clock), .hi (num1_11_ff), .lo ('0), .den (den1_11_ff), .quo (rs)
   );
   frefl_div #(.DW(36), .QW(16)) u_div_f (
      .clock (clock), .hi (num2_11_ff), .lo ('0), .den (den2_11_ff), .quo (f)
   );

   logic zero_d;
   frefl_delay #(.W(1), .N(17)) u_side_c (
      .clock (clock),
      .d_in  ((den1_11_ff == '0) || (den2_11_ff == '0)),
      .d_out (zero_d)
   );

   // C13: parallel term
   logic [33:0] rsf;
   assign rsf = 34'(rs) * 34'(f);

   logic [16:0] rs_13_ff, rp_13_ff;
   logic        zero_13_ff;

   always_ff @(posedge clock) begin
      rs_13_ff   <= rs;
      rp_13_ff   <= rsf[32:16];
      zero_13_ff <= zero_d;
   end

   // C14: average, round, saturate; zero incident index is static config
   logic [17:0] rsum;
   logic [15:0] rnd;
   assign rsum = 18'(rs_13_ff) + 18'(rp_13_ff) + 18'd2;
   assign rnd  = rsum[17:2];

   logic [REFL_W-1:0] refl_ff;

   always_ff @(posedge clock) begin
      if (zero_13_ff || eta_i == '0 || rnd > ONE_Q15) refl_ff <= ONE_Q15;
      else                                            refl_ff <= rnd;
   end

   assign refl = refl_ff;

endmodule

// ===== src/fresnel_reflectance_core.sv =====
// Fresnel reflectance core: one signed Q1.15 incidence cosine in, three
// Q1.15 reflectance channels and a total-internal-reflection flag out.
//
// Input: an item is taken at a rising edge with req_start high and busy low.
// busy never rises; the core takes a new cosine every cycle.
// Output: rsp_valid is high for exactly one cycle per item and marks
// rsp_refl_ch0..2 and rsp_total_internal. The receiver cannot stall; the
// result is simply present for that one cycle.
// Path: an accepted item passes one input register, the conductor pipeline
// and one output register; the shorter dielectric pipeline is padded to
// match. Depth is set by the pipelined square roots and restoring dividers,
// one bit a stage.
// Throughput: one item per cycle, in order.
// Configuration: csr_valid/csr_ready write register csr_index with csr_wdata;
// csr_ready is always high. Write only while no item is in flight.
// Reset (synchronous, active high) restores the register defaults
// (pass-through mode, unit indices, zero absorption) and drops all items in
// flight.
module fresnel_reflectance_core import frefl_pkg::*; (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_start,
   input  logic signed [COS_W-1:0] req_cos_theta,
   output logic                    busy,
   output logic                    rsp_valid,
   output logic [REFL_W-1:0]       rsp_refl_ch0,
   output logic [REFL_W-1:0]       rsp_refl_ch1,
   output logic [REFL_W-1:0]       rsp_refl_ch2,
   output logic                    rsp_total_internal,
   input  logic                    csr_valid,
   output logic                    csr_ready,
   input  logic [CSR_IDX_W-1:0]    csr_index,
   input  logic [CSR_DATA_W-1:0]   csr_wdata
);

   // Configuration registers
   logic [1:0]            mode_ff;
   logic [ETA_W-1:0]      die_eta_i_ff, die_eta_t_ff;
   logic [CSR_DATA_W-1:0] cond_eta_i_ff, cond_eta_t_ff, cond_abs_ff;

   assign csr_ready = 1'b1;
   assign busy      = 1'b0;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff       <= MODE_PASS;
         die_eta_i_ff  <= 16'h1000;
         die_eta_t_ff  <= 16'h1000;
         cond_eta_i_ff <= 48'h1000_1000_1000;
         cond_eta_t_ff <= 48'h1000_1000_1000;
         cond_abs_ff   <= '0;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_MODE:       mode_ff       <= csr_wdata[1:0];
            CSR_DIE_ETA_I:  die_eta_i_ff  <= csr_wdata[ETA_W-1:0];
            CSR_DIE_ETA_T:  die_eta_t_ff  <= csr_wdata[ETA_W-1:0];
            CSR_COND_ETA_I: cond_eta_i_ff <= csr_wdata;
            CSR_COND_ETA_T: cond_eta_t_ff <= csr_wdata;
            CSR_COND_ABS:   cond_abs_ff   <= csr_wdata;
            default: ;  // drop writes to unused indices
         endcase
      end
   end

   // Input register: hold the accepted cosine, advance its valid bit
   logic signed [COS_W-1:0] cos_ff;
   logic                    in_valid_ff;
   logic [COND_LAT-1:0]     valid_pipe_ff;

   always_ff @(posedge clock) begin
      cos_ff <= req_cos_theta;
      if (reset) begin
         in_valid_ff   <= 1'b0;
         valid_pipe_ff <= '0;
      end else begin
         in_valid_ff   <= req_start && !busy;
         valid_pipe_ff <= {valid_pipe_ff[COND_LAT-2:0], in_valid_ff};
      end
   end

   // Dielectric path, padded to the conductor depth
   logic [REFL_W-1:0] die_refl;
   logic              die_tir;
   logic [REFL_W:0]   die_late;

   frefl_dielectric u_dielectric (
      .clock     (clock),
      .cos_theta (cos_ff),
      .eta_i     (die_eta_i_ff),
      .eta_t     (die_eta_t_ff),
      .refl      (die_refl),
      .tir       (die_tir)
   );

   frefl_delay #(.W(REFL_W + 1), .N(COND_LAT - DIE_LAT)) u_die_pad (
      .clock (clock),
      .d_in  ({die_tir, die_refl}),
      .d_out (die_late)
   );

   // Conductor path, one lane per color channel
   logic [REFL_W-1:0] cond_refl [3];

   for (genvar ch = 0; ch < 3; ch++) begin : g_cond
      frefl_conductor u_conductor (
         .clock     (clock),
         .cos_theta (cos_ff),
         .eta_i     (cond_eta_i_ff[ch*ETA_W +: ETA_W]),
         .eta_t     (cond_eta_t_ff[ch*ETA_W +: ETA_W]),
         .kappa     (cond_abs_ff[ch*ETA_W +: ETA_W]),
         .refl      (cond_refl[ch])
      );
   end

   // Output register: select by mode; unused mode code acts as pass-through
   logic              rsp_valid_ff, rsp_tir_ff;
   logic [REFL_W-1:0] rsp_r0_ff, rsp_r1_ff, rsp_r2_ff;

   always_ff @(posedge clock) begin
      if (reset) rsp_valid_ff <= 1'b0;
      else       rsp_valid_ff <= valid_pipe_ff[COND_LAT-1];
      unique case (mode_ff)
         MODE_DIELECTRIC: begin
            rsp_r0_ff  <= die_late[REFL_W-1:0];
            rsp_r1_ff  <= die_late[REFL_W-1:0];
            rsp_r2_ff  <= die_late[REFL_W-1:0];
            rsp_tir_ff <= die_late[REFL_W];
         end
         MODE_CONDUCTOR: begin
            rsp_r0_ff  <= cond_refl[0];
            rsp_r1_ff  <= cond_refl[1];
            rsp_r2_ff  <= cond_refl[2];
            rsp_tir_ff <= 1'b0;
         end
         default: begin
            rsp_r0_ff  <= ONE_Q15;
            rsp_r1_ff  <= ONE_Q15;
            rsp_r2_ff  <= ONE_Q15;
            rsp_tir_ff <= 1'b0;
         end
      endcase
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_refl_ch0       = rsp_r0_ff;
   assign rsp_refl_ch1       = rsp_r1_ff;
   assign rsp_refl_ch2       = rsp_r2_ff;
   assign rsp_total_internal = rsp_tir_ff;

endmodule

// ===== bench/tb_fresnel_reflectance_core.sv =====
module tb_fresnel_reflectance_core;
   import frefl_pkg::*;

   typedef longint unsigned u64_type;

   // One expected result: three reflectance channels and the TIR flag
   typedef struct packed {
      logic [REFL_W-1:0] ch0;
      logic [REFL_W-1:0] ch1;
      logic [REFL_W-1:0] ch2;
      logic              tir;
   } refl_type;

   localparam int PIPE_DEPTH  = 79;       // accept edge to result strobe
   localparam int CYCLE_LIMIT = 1000000;

   logic                    clock = 1'b0;
   logic                    reset = 1'b1;
   logic                    req_start = 1'b0;
   logic signed [COS_W-1:0] req_cos_theta = '0;
   logic                    csr_valid = 1'b0;
   logic [CSR_IDX_W-1:0]    csr_index = '0;
   logic [CSR_DATA_W-1:0]   csr_wdata = '0;
   logic                    busy, rsp_valid, csr_ready, rsp_total_internal;
   logic [REFL_W-1:0]       rsp_refl_ch0, rsp_refl_ch1, rsp_refl_ch2;

   fresnel_reflectance_core u_top (.*);

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Shadow copy of the core's registers, updated as writes are accepted
   logic [1:0]            sh_mode;
   logic [ETA_W-1:0]      sh_die_eta_i, sh_die_eta_t;
   logic [CSR_DATA_W-1:0] sh_cond_eta_i, sh_cond_eta_t, sh_cond_abs;

   refl_type expected_refl[$];
   int       n_errors = 0;
   int       n_cycles = 0;

   // ---------------------------------------------------------------- math

   function automatic u64_type int_sqrt(u64_type x);
      u64_type r, b;
      r = 0;
      b = u64_type'(1) << 62;
      while (b > x) b >>= 2;
      while (b != 0) begin
         if (x >= r + b) begin
            x -= r + b;
            r = (r >> 1) + b;
         end else begin
            r >>= 1;
         end
         b >>= 2;
      end
      return r;
   endfunction

   // floor(a*b / 2^30) without overflowing 64 bits
   function automatic u64_type mul_q30(u64_type a, u64_type b);
      return a * (b >> 30) + ((a * (b & 64'h3FFF_FFFF)) >> 30);
   endfunction

   // sqrt(u^2 + v^2): shift both down until each fits 31 bits, take the floor root, shift back
   function automatic u64_type hypot_scaled(u64_type u, u64_type v);
      int s;
      u64_type us, vs;
      s = 0;
      while ((u >> s) >= (u64_type'(1) << 31) || (v >> s) >= (u64_type'(1) << 31)) s++;
      us = u >> s;
      vs = v >> s;
      return int_sqrt(us * us + vs * vs) << s;
   endfunction

   // Q16 quotient num/den with num clamped to den; returns 0 on a zero den
   function automatic bit ratio_q16(u64_type num, u64_type den, output u64_type q);
      q = 0;
      if (den == 0) return 1'b0;
      if (num > den) num = den;
      q = (num << 16) / den;
      return 1'b1;
   endfunction

   function automatic u64_type sat_one(u64_type v);
      return (v > u64_type'(ONE_Q15)) ? u64_type'(ONE_Q15) : v;
   endfunction

   function automatic u64_type abs_diff(u64_type a, u64_type b);
      return (a >= b) ? a - b : b - a;
   endfunction

   function automatic u64_type dielectric_refl(int cs, output bit tir);
      u64_type ei, et, c, tmp, s2, lhs, et2, ct, a1, b1, a2, b2, q1, q2;
      tir = 1'b0;
      ei  = sh_die_eta_i;
      et  = sh_die_eta_t;
      if (cs > 0) begin
         c = u64_type'(cs);
      end else begin
         // ray exits: swap the two sides
         tmp = ei; ei = et; et = tmp;
         c = u64_type'(-cs);
      end
      if (et == 0) return u64_type'(ONE_Q15);
      s2  = u64_type'(ONE_Q30) - c * c;
      lhs = ei * ei * s2;
      et2 = et * et;
      if (lhs >= (et2 << 30)) begin
         tir = 1'b1;
         return u64_type'(ONE_Q15);
      end
      ct = int_sqrt(u64_type'(ONE_Q30) - lhs / et2);
      a1 = et * c;  b1 = ei * ct;
      a2 = ei * c;  b2 = et * ct;
      if (!ratio_q16(abs_diff(a1, b1), a1 + b1, q1)) return u64_type'(ONE_Q15);
      if (!ratio_q16(abs_diff(a2, b2), a2 + b2, q2)) return u64_type'(ONE_Q15);
      return sat_one((q1 * q1 + q2 * q2 + (u64_type'(1) << 17)) >> 18);
   endfunction

   function automatic u64_type conductor_refl(u64_type c, int ch);
      u64_type ii, ee, kk, i2, c2, s2, ut0, a, ah, x1, y1, x2, y2, rs, f, rp;
      longint  t0, h;
      ii = (sh_cond_eta_i >> (16 * ch)) & 16'hFFFF;
      ee = (sh_cond_eta_t >> (16 * ch)) & 16'hFFFF;
      kk = (sh_cond_abs   >> (16 * ch)) & 16'hFFFF;
      if (ii == 0) return u64_type'(ONE_Q15);
      i2  = ii * ii;
      c2  = c * c;
      s2  = u64_type'(ONE_Q30) - c2;
      t0  = longint'(ee * ee) - longint'(kk * kk) - longint'(mul_q30(s2, i2));
      ut0 = (t0 < 0) ? u64_type'(-t0) : u64_type'(t0);
      a   = hypot_scaled(ut0, 2 * ee * kk);
      h   = longint'(a) + t0;
      if (h < 0) h = 0;
      ah  = int_sqrt(u64_type'(h) >> 1);
      x1  = a + mul_q30(c2, i2);
      y1  = (2 * c * ii * ah) >> 15;
      if (!ratio_q16((x1 > y1) ? x1 - y1 : 0, x1 + y1, rs)) return u64_type'(ONE_Q15);
      x2  = mul_q30(c2, a) + mul_q30(mul_q30(s2, s2), i2);
      y2  = mul_q30(s2, y1);
      if (!ratio_q16((x2 > y2) ? x2 - y2 : 0, x2 + y2, f)) return u64_type'(ONE_Q15);
      rp  = (rs * f) >> 16;
      return sat_one((rs + rp + 2) >> 2);
   endfunction

   function automatic refl_type predict_refl(logic signed [COS_W-1:0] cos_in);
      refl_type r;
      int       cs;
      bit       tir;
      u64_type  c;
      cs = int'(cos_in);
      r  = '{ch0: ONE_Q15, ch1: ONE_Q15, ch2: ONE_Q15, tir: 1'b0};
      if (sh_mode == MODE_DIELECTRIC) begin
         r.ch0 = REFL_W'(dielectric_refl(cs, tir));
         r.ch1 = r.ch0;
         r.ch2 = r.ch0;
         r.tir = tir;
      end else if (sh_mode == MODE_CONDUCTOR) begin
         c = u64_type'((cs < 0) ? -cs : cs);
         r.ch0 = REFL_W'(conductor_refl(c, 0));
         r.ch1 = REFL_W'(conductor_refl(c, 1));
         r.ch2 = REFL_W'(conductor_refl(c, 2));
      end
      // any other code, including the unused one, answers 1.0
      return r;
   endfunction

   // ------------------------------------------------- monitor and checker

   // Sample at the rising edge: inputs and outputs still hold their pre-edge
   // values, so acceptance and results are seen exactly as the core sees them.
   always @(posedge clock) begin
      refl_type want;
      n_cycles++;
      if (n_cycles > CYCLE_LIMIT) begin
         $display("fresnel_reflectance_core: mismatch");
         $finish;
      end
      if (!reset && req_start && !busy)
         expected_refl.push_back(predict_refl(req_cos_theta));
      if (!reset && rsp_valid) begin
         if (expected_refl.size() == 0) begin
            $error("result with no item outstanding");
            n_errors++;
         end else begin
            want = expected_refl.pop_front();
            if (rsp_refl_ch0 !== want.ch0) begin
               $error("refl_ch0 expected %0d got %0d", want.ch0, rsp_refl_ch0);
               n_errors++;
            end
            if (rsp_refl_ch1 !== want.ch1) begin
               $error("refl_ch1 expected %0d got %0d", want.ch1, rsp_refl_ch1);
               n_errors++;
            end
            if (rsp_refl_ch2 !== want.ch2) begin
               $error("refl_ch2 expected %0d got %0d", want.ch2, rsp_refl_ch2);
               n_errors++;
            end
            if (rsp_total_internal !== want.tir) begin
               $error("total_internal expected %0d got %0d", want.tir,
                      rsp_total_internal);
               n_errors++;
            end
         end
      end
   end

   // ----------------------------------------------------------- drivers

   // Mostly back to back, some short gaps, now and then a long one
   function automatic int pick_gap();
      int r;
      r = $urandom_range(99);
      if (r < 55) return 0;
      if (r < 95) return $urandom_range(3, 1);
      return $urandom_range(40, 10);
   endfunction

   // Hold the item until the core takes it, then maybe idle a while
   task automatic send_cos(logic signed [COS_W-1:0] cos_val, bit gaps);
      int gap;
      req_start     <= 1'b1;
      req_cos_theta <= cos_val;
      do @(posedge clock); while (busy);
      gap = gaps ? pick_gap() : 0;
      if (gap > 0) begin
         req_start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // Stop sending and wait until every result is back
   task automatic drain();
      req_start <= 1'b0;
      @(posedge clock);
      while (expected_refl.size() != 0) @(posedge clock);
   endtask

   task automatic write_csr(csr_index_type idx, logic [CSR_DATA_W-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      case (idx)
         CSR_MODE:       sh_mode       = data[1:0];
         CSR_DIE_ETA_I:  sh_die_eta_i  = data[ETA_W-1:0];
         CSR_DIE_ETA_T:  sh_die_eta_t  = data[ETA_W-1:0];
         CSR_COND_ETA_I: sh_cond_eta_i = data;
         CSR_COND_ETA_T: sh_cond_eta_t = data;
         CSR_COND_ABS:   sh_cond_abs   = data;
         default: ;
      endcase
   endtask

   function automatic logic [ETA_W-1:0] pick_eta();
      int r;
      r = $urandom_range(15);
      if (r == 0) return '0;
      if (r == 1) return '1;
      if (r < 10) return ETA_W'($urandom_range(12288, 2048));
      return ETA_W'($urandom());
   endfunction

   function automatic logic [CSR_DATA_W-1:0] pick_eta3();
      return {pick_eta(), pick_eta(), pick_eta()};
   endfunction

   function automatic logic signed [COS_W-1:0] pick_cos();
      int r;
      r = $urandom_range(19);
      case (r)
         0: return 16'sh8000;
         1: return 16'sh7FFF;
         2: return '0;
         3: return COS_W'($urandom_range(64)) - 16'sd32;
         default: return COS_W'($urandom());
      endcase
   endfunction

   // ------------------------------------------------------------- tests

   // Reset state: pass-through, every channel one
   task automatic test_reset_state();
      send_cos(16'sh8000, 0);
      send_cos(16'sh7FFF, 0);
      send_cos(16'sh0000, 0);
      drain();
   endtask

   task automatic test_dielectric();
      write_csr(CSR_MODE, CSR_DATA_W'(MODE_DIELECTRIC));
      write_csr(CSR_DIE_ETA_I, 48'd4096);
      write_csr(CSR_DIE_ETA_T, 48'd6144);        // air into glass
      send_cos(16'sh7FFF, 0);
      send_cos(16'sh0001, 0);
      send_cos(16'sh0000, 0);                    // zero cosine counts as exiting
      send_cos(-16'sd1, 0);
      send_cos(-16'sd4000, 0);                   // exiting at grazing angle: TIR
      send_cos(16'sh8000, 0);                    // straight out
      drain();
      // zero index on the far side of an entering ray
      write_csr(CSR_DIE_ETA_T, 48'd0);
      send_cos(16'sd20000, 0);
      drain();
      write_csr(CSR_DIE_ETA_I, 48'd0);
      write_csr(CSR_DIE_ETA_T, 48'hFFFF);
      send_cos(-16'sd20000, 0);
      send_cos(16'sd20000, 0);
      drain();
   endtask

   task automatic test_conductor();
      write_csr(CSR_MODE, CSR_DATA_W'(MODE_CONDUCTOR));
      write_csr(CSR_COND_ETA_I, {16'd4096, 16'd0, 16'hFFFF});  // one channel zero
      write_csr(CSR_COND_ETA_T, {16'd800, 16'd1200, 16'hFFFF});
      write_csr(CSR_COND_ABS, {16'd14000, 16'd0, 16'hFFFF});
      send_cos(16'sh7FFF, 0);
      send_cos(16'sh8000, 0);
      send_cos(16'sh0000, 0);
      send_cos(16'sd1, 0);
      send_cos(-16'sd12345, 0);
      drain();
      write_csr(CSR_COND_ETA_T, 48'd0);          // all-zero index and absorption
      write_csr(CSR_COND_ABS, 48'd0);
      send_cos(16'sd16384, 0);
      send_cos(16'sh0000, 0);
      drain();
   endtask

   // The unused mode code behaves as pass-through
   task automatic test_unused_mode();
      write_csr(CSR_MODE, 48'd3);
      send_cos(16'sd1000, 0);
      send_cos(16'sh8000, 0);
      drain();
   endtask

   // Random phases: fresh settings, then a burst of cosines with gaps
   task automatic test_random(int n_items);
      int done, burst, i;
      done = 0;
      while (done < n_items) begin
         write_csr(CSR_MODE, CSR_DATA_W'($urandom_range(9) < 4 ? MODE_DIELECTRIC :
                   ($urandom_range(9) < 8 ? MODE_CONDUCTOR :
                    ($urandom_range(1) ? MODE_PASS : 2'd3))));
         write_csr(CSR_DIE_ETA_I, CSR_DATA_W'(pick_eta()));
         write_csr(CSR_DIE_ETA_T, CSR_DATA_W'(pick_eta()));
         write_csr(CSR_COND_ETA_I, pick_eta3());
         write_csr(CSR_COND_ETA_T, pick_eta3());
         write_csr(CSR_COND_ABS, pick_eta3());
         burst = $urandom_range(120, 40);
         for (i = 0; i < burst; i++) send_cos(pick_cos(), 1);
         done += burst;
         drain();
         // the core answers every item, but let the pipe settle anyway
         repeat (4) @(posedge clock);
      end
   endtask

   initial begin
      sh_mode       = MODE_PASS;
      sh_die_eta_i  = 16'd4096;
      sh_die_eta_t  = 16'd4096;
      sh_cond_eta_i = 48'h1000_1000_1000;
      sh_cond_eta_t = 48'h1000_1000_1000;
      sh_cond_abs   = '0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_reset_state();
      test_dielectric();
      test_conductor();
      test_unused_mode();
      test_random(1100);

      drain();
      repeat (PIPE_DEPTH + 20) @(posedge clock);
      if (n_errors == 0 && expected_refl.size() == 0) begin
         $display("fresnel_reflectance_core: match");
      end else begin
         $display("fresnel_reflectance_core: mismatch");
      end
      $finish;
   end

endmodule
